>>> src/epoch_seconds_to_calendar_date_unit_defines.svh
// Assertion macros shared by the calendar date unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked outside of reset.
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ESC_ASSERT(lbl, prop, msg)
`define ESC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/esc_pkg.sv
// Package of the calendar date unit: beat types, state codes, constants and calendar helpers.
// Depends on nothing; esc_cmp_sub and the top module import it.
package esc_pkg;

    // Datapath width of the shared compare-subtract unit.
    localparam int ESC_W = 32;

    // Quotient bits produced by each long-division phase.
    localparam int DAY_Q_BITS  = 16;
    localparam int HOUR_Q_BITS = 5;
    localparam int MIN_Q_BITS  = 6;

    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 3600 * 24;

    // Divisors aligned to the top quotient bit of each phase.
    localparam logic [ESC_W-1:0] DAY_DIV_INIT  = ESC_W'(SECS_PER_DAY) << (DAY_Q_BITS - 1);
    localparam logic [ESC_W-1:0] HOUR_DIV_INIT = ESC_W'(SECS_PER_HOUR) << (HOUR_Q_BITS - 1);
    localparam logic [ESC_W-1:0] MIN_DIV_INIT  = ESC_W'(SECS_PER_MIN) << (MIN_Q_BITS - 1);

    // Year 1970 counted from 1900.
    localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;
    localparam logic [8:0] YEAR_DAYS      = 9'd365;
    localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
    localparam logic [3:0] MON_FEB        = 4'd1;
    localparam logic [3:0] MON_DEC        = 4'd11;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [31:0] timestamp;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] year_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MON,
        S_OUT
    } t_esc_state;

    // Gregorian leap rule on a year counted from 1900. Over 1900..2155 the only
    // centuries are 1900 and 2100 (common) and 2000 (leap).
    function automatic logic esc_is_leap(input logic [7:0] year_ofs);
        logic div4;
        div4 = (year_ofs[1:0] == 2'b00);
        return div4 && (year_ofs != 8'd0) && (year_ofs != 8'd200);
    endfunction

    // Days in a month, February stretched in a leap year.
    function automatic logic [4:0] esc_month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        len = (mon <= MON_DEC) ? MONTH_LEN[mon] : 5'd31;
        if (mon == MON_FEB && leap) begin
            len = len + 5'd1;
        end
        return len;
    endfunction

endpackage

>>> src/esc_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// The payload type is given by the instantiating level; no other dependencies.
interface esc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/esc_cmp_sub.sv
// Shared compare-subtract unit of the calendar date unit.
// Depends on esc_pkg for the datapath width.
module esc_cmp_sub (
    input  logic [esc_pkg::ESC_W-1:0] i_a,
    input  logic [esc_pkg::ESC_W-1:0] i_b,
    output logic [esc_pkg::ESC_W-1:0] o_diff,
    output logic                      o_ge
);
    import esc_pkg::*;

    logic [ESC_W:0] wide_diff;

    // One subtraction; the borrow out doubles as the compare.
    assign wide_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff    = wide_diff[ESC_W-1:0];
    assign o_ge      = ~wide_diff[ESC_W];
endmodule

>>> src/epoch_seconds_to_calendar_date_unit.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the UTC date and
// time: years since 1900, zero-based month, one-based day, hour, minute and second. One
// timestamp beat is taken at a time; all work runs through a single 32-bit compare-subtract
// unit under a small sequencer. After a beat is accepted, the sequencer runs restoring
// division for days, hours and minutes (16, 5 and 6 quotient bits), strips whole years
// past 1970 one at a time, strips whole months one at a time, and then loads the output
// register. The load waits while the previous result is still held and not taken, and the
// sequencer returns to idle before the next beat is taken.
// The next timestamp is accepted as soon as the result sits in the output register, even
// while that result has not been taken yet.
// Depends on esc_pkg, esc_stream_if, esc_cmp_sub and the assertion macro header.
`include "epoch_seconds_to_calendar_date_unit_defines.svh"

module epoch_seconds_to_calendar_date_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esc_stream_if.sink    i_ts,
    esc_stream_if.source  o_date
);
    import esc_pkg::*;

    t_esc_state       r_state, n_state;
    logic [ESC_W-1:0] r_acc, n_acc;
    logic [ESC_W-1:0] r_div, n_div;
    logic [15:0]      r_q, n_q;
    logic [3:0]       r_k, n_k;
    logic [15:0]      r_days, n_days;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_min, n_min;
    logic [5:0]       r_sec, n_sec;
    logic [7:0]       r_year, n_year;
    logic [3:0]       r_mon, n_mon;
    logic             r_ovalid, n_ovalid;
    t_out_beat        r_out, n_out;

    logic [ESC_W-1:0] unit_b;
    logic [ESC_W-1:0] unit_diff;
    logic             unit_ge;
    logic             leap;
    logic [ESC_W-1:0] rem_next;
    logic             in_beat;
    logic             out_free;
    logic             out_in_range;

    assign leap     = esc_is_leap(r_year);
    assign rem_next = unit_ge ? unit_diff : r_acc;
    assign in_beat  = i_ts.valid && i_ts.ready;
    assign out_free = !r_ovalid || o_date.ready;

    assign i_ts.ready     = (r_state == S_IDLE);
    assign o_date.valid   = r_ovalid;
    assign o_date.payload = r_out;

    // Second operand of the shared unit, picked by the phase.
    always_comb begin
        unique case (r_state)
            S_DAY, S_HOUR, S_MIN: unit_b = r_div;
            S_YEAR:               unit_b = ESC_W'(leap ? LEAP_YEAR_DAYS : YEAR_DAYS);
            S_MON:                unit_b = ESC_W'(esc_month_len(r_mon, leap));
            default:              unit_b = '0;
        endcase
    end

    esc_cmp_sub u_cmp_sub (
        .i_a    (r_acc),
        .i_b    (unit_b),
        .o_diff (unit_diff),
        .o_ge   (unit_ge)
    );

    // Sequencer: next state and next values of the working registers.
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_div    = r_div;
        n_q      = r_q;
        n_k      = r_k;
        n_days   = r_days;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        n_year   = r_year;
        n_mon    = r_mon;
        n_out    = r_out;
        n_ovalid = r_ovalid;

        // The waiting result leaves when the sink takes it.
        if (r_ovalid && o_date.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_acc   = i_ts.payload.timestamp;
                    n_div   = DAY_DIV_INIT;
                    n_k     = 4'(DAY_Q_BITS - 1);
                    n_state = S_DAY;
                end
            end
            S_DAY, S_HOUR, S_MIN: begin
                // One restoring-division step per cycle.
                n_acc = rem_next;
                n_q   = {r_q[14:0], unit_ge};
                n_div = r_div >> 1;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    unique case (r_state)
                        S_DAY: begin
                            n_days  = {r_q[14:0], unit_ge};
                            n_div   = HOUR_DIV_INIT;
                            n_k     = 4'(HOUR_Q_BITS - 1);
                            n_state = S_HOUR;
                        end
                        S_HOUR: begin
                            n_hour  = {r_q[3:0], unit_ge};
                            n_div   = MIN_DIV_INIT;
                            n_k     = 4'(MIN_Q_BITS - 1);
                            n_state = S_MIN;
                        end
                        default: begin
                            n_min   = {r_q[4:0], unit_ge};
                            n_sec   = rem_next[5:0];
                            n_acc   = ESC_W'(r_days);
                            n_year  = EPOCH_YEAR_OFS;
                            n_state = S_YEAR;
                        end
                    endcase
                end
            end
            S_YEAR: begin
                // Strip whole years while the day count covers them.
                if (unit_ge) begin
                    n_acc  = unit_diff;
                    n_year = r_year + 8'd1;
                end else begin
                    n_mon   = 4'd0;
                    n_state = S_MON;
                end
            end
            S_MON: begin
                // Strip whole months; December takes whatever is left.
                if (unit_ge && (r_mon != MON_DEC)) begin
                    n_acc = unit_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out.year_since_1900  = r_year;
                    n_out.month_index      = r_mon;
                    n_out.day_of_month     = r_acc[4:0] + 5'd1;
                    n_out.hour_of_day      = r_hour;
                    n_out.minute_of_hour   = r_min;
                    n_out.second_of_minute = r_sec;
                    n_ovalid               = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_div  <= n_div;
        r_q    <= n_q;
        r_k    <= n_k;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_out  <= n_out;
    end

    // Time of day and month of the held result lie in their ranges.
    assign out_in_range = (r_out.hour_of_day < 5'd24) && (r_out.minute_of_hour < 6'd60)
                          && (r_out.second_of_minute < 6'd60) && (r_out.month_index <= MON_DEC);

    // An accepted beat always starts the day division.
    `ESC_ASSERT(a_accept_starts_division, in_beat |=> (r_state == S_DAY), "no division start")
    // A new result appears only out of the output-load step.
    `ESC_ASSERT(a_result_from_load, $rose(r_ovalid) |-> $past(r_state == S_OUT), "stray result")
    // The year walk never passes the last year a 32-bit count can reach.
    `ESC_ASSERT(a_year_in_range, (r_state == S_YEAR) |-> (r_year <= 8'd206), "year past 2106")
    // A delivered beat carries a time of day and a month in range.
    `ESC_ASSERT(a_time_in_range, r_ovalid |-> out_in_range, "result field out of range")
    // Reset clears the valid flag of the output register.
    `ESC_ASSERT_ALWAYS(a_reset_clears_output, !i_rst_n |=> !r_ovalid, "valid survived reset")
endmodule
